// ===== rtl/core/glass_teletype_video_and_key_latch_assert.svh =====
// assertion macros for the glass teletype video port checker
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef GLASS_TELETYPE_VIDEO_AND_KEY_LATCH_ASSERT_SVH
`define GLASS_TELETYPE_VIDEO_AND_KEY_LATCH_ASSERT_SVH

// same-cycle implication, off during reset
`define GTT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// next-cycle implication, off during reset
`define GTT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

// what must hold in the cycle after reset is seen
`define GTT_ASSERT_RST(label, cons) \
    label: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) \
        else $error("%m: post-reset check failed");

`endif

// ===== rtl/core/gtt_pkg.sv =====
// shared types and constants of the glass teletype video port
// no dependencies
`default_nettype none

package gtt_pkg;

    // screen geometry (power-of-two sizes, row ring indexed by bits)
    localparam int COL_BITS = 5;
    localparam int ROW_BITS = 4;
    localparam int COLUMNS  = 1 << COL_BITS;
    localparam int ROWS     = 1 << ROW_BITS;
    localparam int CELLS    = COLUMNS * ROWS;
    localparam int ADDR_W   = ROW_BITS + COL_BITS;

    // field widths
    localparam int CHAR_W      = 7;
    localparam int CMD_W       = 2;
    localparam int DATA_W      = 8;
    localparam int OFF_W       = 9;
    localparam int RD_W        = 8;
    localparam int CUR_OUT_W   = 5;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 16;

    // character codes
    localparam logic [CHAR_W-1:0] SPACE_CODE = 7'd32;
    localparam logic [CHAR_W-1:0] MARK_CODE  = 7'h7F;
    localparam logic [CHAR_W-1:0] BS_CODE    = 7'd8;
    localparam logic [CHAR_W-1:0] CR_CODE    = 7'd13;

    // fixed positions
    localparam logic [COL_BITS-1:0] COL_LAST  = COL_BITS'(COLUMNS - 1);
    localparam logic [ROW_BITS-1:0] ROW_LAST  = ROW_BITS'(ROWS - 1);
    localparam logic [ADDR_W-1:0]   CELL_LAST = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0]   MARK_ADDR = {ROW_LAST, {COL_BITS{1'b0}}};

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_KEY   = 2'd2,
        CMD_KBD   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_FILL,
        ST_SCROLL,
        ST_MARK,
        ST_RDWAIT,
        ST_DONE
    } t_state;

    // write address source
    typedef enum logic [1:0] {
        AS_CURSOR,
        AS_COUNT,
        AS_CLEAR
    } t_asel;

    // write data source
    typedef enum logic [1:0] {
        WS_SPACE,
        WS_CHAR,
        WS_MARK,
        WS_INIT
    } t_wsel;

    typedef enum logic [1:0] {
        CUR_HOLD,
        CUR_INC,
        CUR_DEC,
        CUR_ZERO
    } t_cur_op;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_LOAD,
        CNT_ZERO,
        CNT_INC
    } t_cnt_op;

    typedef enum logic [1:0] {
        RES_HOLD,
        RES_ZERO,
        RES_KEY,
        RES_MEM
    } t_res_op;

    // controller to datapath
    typedef struct packed {
        logic    capture;
        logic    mem_we;
        t_asel   asel;
        t_wsel   wsel;
        logic    rd_en;
        logic    clr_inc;
        t_cur_op cur_op;
        t_cnt_op cnt_op;
        logic    top_inc;
        t_res_op res_op;
        logic    key_load;
        logic    key_clear;
        logic    out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        t_cmd cmd;
        logic is_bs;
        logic is_cr;
        logic is_print;
        logic cur_zero;
        logic cur_last;
        logic cnt_last;
        logic clr_last;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== rtl/core/glass_teletype_video_and_key_latch.sv =====
// A key or keyboard command goes from DECODE to DONE, a memory read passes RDWAIT, and a
// plain character write passes MARK; a write that scrolls clears the new row in SCROLL first,
// and a carriage return adds the row fill in FILL before SCROLL (one cell a cycle).
// One item is in flight at a time; the next is taken in the cycle after the result loads.
// After reset a clearing pass sets up all 512 cells, one a cycle; no input is taken then.
`default_nettype none

module glass_teletype_video_and_key_latch (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    // [7:0] data, [16:8] offset, [17] running, rest zero
    input  wire [gtt_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // [1:0] cmd
    input  wire [gtt_pkg::CMD_W-1:0]         s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // [7:0] read_data, [12:8] cursor_column, rest zero
    output logic [gtt_pkg::M_TDATA_W-1:0]    m_axis_tdata
);
    import gtt_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencer
    gtt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // screen, cursor, key latch and output stage
    gtt_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

// ===== rtl/core/gtt_ctrl.sv =====
// control state machine of the glass teletype video port
// depends on gtt_pkg
`default_nettype none

module gtt_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  gtt_pkg::t_dp_stat  i_stat,
    output gtt_pkg::t_dp_cmd   o_cmd
);
    import gtt_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_stat.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                unique case (i_stat.cmd)
                    CMD_WRITE: begin
                        if (i_stat.is_cr) begin
                            n_state = ST_FILL;
                        end else if (i_stat.is_print && i_stat.cur_last) begin
                            n_state = ST_SCROLL;
                        end else begin
                            n_state = ST_MARK;
                        end
                    end
                    CMD_READ: n_state = ST_RDWAIT;
                    default:  n_state = ST_DONE;
                endcase
            end
            ST_FILL: begin
                if (i_stat.cnt_last) n_state = ST_SCROLL;
            end
            ST_SCROLL: begin
                if (i_stat.cnt_last) n_state = ST_MARK;
            end
            ST_MARK:   n_state = ST_DONE;
            ST_RDWAIT: n_state = ST_DONE;
            ST_DONE: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.mem_we  = 1'b1;
                o_cmd.asel    = AS_CLEAR;
                o_cmd.wsel    = WS_INIT;
                o_cmd.clr_inc = 1'b1;
            end
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_DECODE: begin
                unique case (i_stat.cmd)
                    CMD_WRITE: begin
                        if (i_stat.is_bs && !i_stat.cur_zero) begin
                            // clear the old mark cell, step back
                            o_cmd.mem_we = 1'b1;
                            o_cmd.asel   = AS_CURSOR;
                            o_cmd.wsel   = WS_SPACE;
                            o_cmd.cur_op = CUR_DEC;
                        end else if (i_stat.is_cr) begin
                            o_cmd.cnt_op = CNT_LOAD;
                        end else if (i_stat.is_print) begin
                            o_cmd.mem_we = 1'b1;
                            o_cmd.asel   = AS_CURSOR;
                            o_cmd.wsel   = WS_CHAR;
                            if (i_stat.cur_last) begin
                                o_cmd.top_inc = 1'b1;
                                o_cmd.cnt_op  = CNT_ZERO;
                            end else begin
                                o_cmd.cur_op = CUR_INC;
                            end
                        end
                    end
                    CMD_READ: begin
                        o_cmd.rd_en = 1'b1;
                    end
                    CMD_KEY: begin
                        o_cmd.key_load = 1'b1;
                        o_cmd.res_op   = RES_ZERO;
                    end
                    default: begin
                        o_cmd.res_op    = RES_KEY;
                        o_cmd.key_clear = 1'b1;
                    end
                endcase
            end
            ST_FILL: begin
                // blank the rest of the bottom row before it scrolls
                o_cmd.mem_we = 1'b1;
                o_cmd.asel   = AS_COUNT;
                o_cmd.wsel   = WS_SPACE;
                if (i_stat.cnt_last) begin
                    o_cmd.top_inc = 1'b1;
                    o_cmd.cnt_op  = CNT_ZERO;
                end else begin
                    o_cmd.cnt_op = CNT_INC;
                end
            end
            ST_SCROLL: begin
                // clear the new bottom row
                o_cmd.mem_we = 1'b1;
                o_cmd.asel   = AS_COUNT;
                o_cmd.wsel   = WS_SPACE;
                if (i_stat.cnt_last) begin
                    o_cmd.cur_op = CUR_ZERO;
                end else begin
                    o_cmd.cnt_op = CNT_INC;
                end
            end
            ST_MARK: begin
                o_cmd.mem_we = 1'b1;
                o_cmd.asel   = AS_CURSOR;
                o_cmd.wsel   = WS_MARK;
                o_cmd.res_op = RES_ZERO;
            end
            ST_RDWAIT: begin
                o_cmd.res_op = RES_MEM;
            end
            ST_DONE: begin
                o_cmd.out_load = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/gtt_dp.sv =====
// datapath of the glass teletype video port: screen memory, cursor,
// row ring base, key latch and output register; depends on gtt_pkg
`default_nettype none

module gtt_dp (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  gtt_pkg::t_dp_cmd                i_cmd,
    output gtt_pkg::t_dp_stat               o_stat,
    input  wire [gtt_pkg::S_TDATA_W-1:0]    i_s_tdata,
    input  wire [gtt_pkg::CMD_W-1:0]        i_s_tuser,
    output logic                            o_m_tvalid,
    input  wire                             i_m_tready,
    output logic [gtt_pkg::M_TDATA_W-1:0]   o_m_tdata
);
    import gtt_pkg::*;

    // captured transaction
    t_cmd              r_cmd;
    logic [DATA_W-1:0] r_data;
    logic [OFF_W-1:0]  r_offset;
    logic              r_running;

    // screen and control state
    logic [CHAR_W-1:0]   r_mem [CELLS];
    logic [CHAR_W-1:0]   r_mem_q;
    logic [COL_BITS-1:0] r_cursor;
    logic [COL_BITS-1:0] r_count;
    logic [ROW_BITS-1:0] r_top;
    logic [ADDR_W-1:0]   r_clr_ptr;
    logic [DATA_W-1:0]   r_key;
    logic [RD_W-1:0]     r_res;

    // output register
    logic                 r_m_valid;
    logic [RD_W-1:0]      r_out_data;
    logic [CUR_OUT_W-1:0] r_out_cur;

    logic [CHAR_W-1:0]   w_char;
    logic [ROW_BITS-1:0] w_bot_row;
    logic [ADDR_W-1:0]   w_ofs;
    logic [ADDR_W-1:0]   w_rd_addr;
    logic [ADDR_W-1:0]   n_wr_addr;
    logic [CHAR_W-1:0]   n_wr_data;
    logic                w_in_range;

    assign w_char     = r_data[CHAR_W-1:0];
    assign w_bot_row  = r_top + ROW_LAST;
    assign w_ofs      = ADDR_W'(r_offset);
    assign w_rd_addr  = {w_ofs[ADDR_W-1:COL_BITS] + r_top, w_ofs[COL_BITS-1:0]};
    assign w_in_range = 32'(r_offset) < CELLS;

    // capture the accepted transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd     <= t_cmd'(i_s_tuser);
            r_data    <= i_s_tdata[DATA_W-1:0];
            r_offset  <= i_s_tdata[DATA_W +: OFF_W];
            r_running <= i_s_tdata[DATA_W + OFF_W];
        end
    end

    // write address select
    always_comb begin
        case (i_cmd.asel)
            AS_CURSOR: n_wr_addr = {w_bot_row, r_cursor};
            AS_COUNT:  n_wr_addr = {w_bot_row, r_count};
            default:   n_wr_addr = r_clr_ptr;
        endcase
    end

    // write data select
    always_comb begin
        case (i_cmd.wsel)
            WS_SPACE: n_wr_data = SPACE_CODE;
            WS_CHAR:  n_wr_data = w_char;
            WS_MARK:  n_wr_data = MARK_CODE;
            default:  n_wr_data = (r_clr_ptr == MARK_ADDR) ? MARK_CODE : SPACE_CODE;
        endcase
    end

    // screen memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            r_mem[n_wr_addr] <= n_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_mem_q <= r_mem[w_rd_addr];
        end
    end

    // cursor column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
        end else begin
            case (i_cmd.cur_op)
                CUR_INC:  r_cursor <= r_cursor + 1'b1;
                CUR_DEC:  r_cursor <= r_cursor - 1'b1;
                CUR_ZERO: r_cursor <= '0;
                default:  r_cursor <= r_cursor;
            endcase
        end
    end

    // column sweep counter
    always_ff @(posedge i_clk) begin
        case (i_cmd.cnt_op)
            CNT_LOAD: r_count <= r_cursor;
            CNT_ZERO: r_count <= '0;
            CNT_INC:  r_count <= r_count + 1'b1;
            default:  r_count <= r_count;
        endcase
    end

    // ring base row and post-reset clear pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top     <= '0;
            r_clr_ptr <= '0;
        end else begin
            if (i_cmd.top_inc) r_top <= r_top + 1'b1;
            if (i_cmd.clr_inc) r_clr_ptr <= r_clr_ptr + 1'b1;
        end
    end

    // key latch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cmd.key_load && (r_data != '0) && r_running) begin
            r_key <= r_data;
        end else if (i_cmd.key_clear) begin
            r_key <= '0;
        end
    end

    // result value
    always_ff @(posedge i_clk) begin
        case (i_cmd.res_op)
            RES_ZERO: r_res <= '0;
            RES_KEY:  r_res <= RD_W'(r_key);
            RES_MEM:  r_res <= w_in_range ? RD_W'(r_mem_q) : '0;
            default:  r_res <= r_res;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= r_res;
            r_out_cur  <= CUR_OUT_W'(r_cursor);
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = M_TDATA_W'({r_out_cur, r_out_data});

    // status back to the controller
    always_comb begin
        o_stat.cmd      = r_cmd;
        o_stat.is_bs    = (w_char == BS_CODE);
        o_stat.is_cr    = (w_char == CR_CODE);
        o_stat.is_print = (w_char >= SPACE_CODE);
        o_stat.cur_zero = (r_cursor == '0);
        o_stat.cur_last = (r_cursor == COL_LAST);
        o_stat.cnt_last = (r_count == COL_LAST);
        o_stat.clr_last = (r_clr_ptr == CELL_LAST);
        o_stat.out_free = !r_m_valid || i_m_tready;
    end

endmodule

`default_nettype wire

// ===== rtl/core/gtt_chk.sv =====
// port-level checks of the glass teletype video port, bound to the top level
// depends on gtt_pkg and glass_teletype_video_and_key_latch_assert.svh
`default_nettype none

`include "glass_teletype_video_and_key_latch_assert.svh"

module gtt_chk (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             s_axis_tvalid,
    input  wire                             s_axis_tready,
    input  wire [gtt_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    input  wire [gtt_pkg::CMD_W-1:0]        s_axis_tuser,
    input  wire                             m_axis_tvalid,
    input  wire                             m_axis_tready,
    input  wire [gtt_pkg::M_TDATA_W-1:0]    m_axis_tdata
);
    import gtt_pkg::*;

    // reset leaves no result pending and holds off input during the clear pass
    `GTT_ASSERT_RST(a_rst_quiet, !m_axis_tvalid && !s_axis_tready)

    // one item at a time: input closes right after a transaction
    `GTT_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // a waiting input transaction keeps its fields
    `GTT_ASSERT_NEXT(a_in_hold, s_axis_tvalid && !s_axis_tready,
                     s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))

    // a stalled result holds
    `GTT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                     m_axis_tvalid && $stable(m_axis_tdata))

    // padding bits above the cursor field stay zero
    `GTT_ASSERT_NOW(a_out_pad, m_axis_tvalid,
                    m_axis_tdata[M_TDATA_W-1:RD_W+CUR_OUT_W] == '0)

endmodule

bind glass_teletype_video_and_key_latch gtt_chk u_chk (.*);

`default_nettype wire

// ===== tb/sv/tb.sv =====
// self-checking testbench for the glass teletype video port and key latch
// depends on gtt_pkg and the glass_teletype_video_and_key_latch rtl
`timescale 1ns / 1ps

module tb;
    import gtt_pkg::*;

    localparam int BOTTOM_BASE  = CELLS - COLUMNS;
    localparam int RANDOM_ITEMS = 1700;
    localparam int PHASE_COUNT  = 5;
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int REPORT_MAX   = 10;

    // idle and stall percentages per random phase
    localparam int PHASE_IDLE  [PHASE_COUNT] = '{0, 59, 0, 17, 0};
    localparam int PHASE_STALL [PHASE_COUNT] = '{0, 0, 59, 17, 0};

    typedef struct packed {
        logic [RD_W-1:0]      read_data;
        logic [CUR_OUT_W-1:0] cursor;
    } t_port_result;

    typedef struct packed {
        t_cmd              cmd;
        logic [DATA_W-1:0] data;
        logic [OFF_W-1:0]  offset;
        logic              running;
        logic              typed;
        t_port_result      result;
    } t_stim_row;

    localparam int DIRECTED_COUNT = 25;

    // directed rows; typed results where they are plain, the rest predicted
    localparam t_stim_row DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // screen contents right after reset
        '{CMD_READ,  8'h00, 9'd480, 1'b0, 1'b1, '{{1'b0, MARK_CODE}, 5'd0}},
        '{CMD_READ,  8'hFF, 9'd0,   1'b1, 1'b1, '{{1'b0, SPACE_CODE}, 5'd0}},
        '{CMD_READ,  8'h00, 9'd511, 1'b0, 1'b1, '{{1'b0, SPACE_CODE}, 5'd0}},
        // keyboard empty, zero key, key while stopped
        '{CMD_KBD,   8'h00, 9'd0,   1'b0, 1'b1, '{8'h00, 5'd0}},
        '{CMD_KEY,   8'h00, 9'd0,   1'b1, 1'b1, '{8'h00, 5'd0}},
        '{CMD_KEY,   8'h41, 9'd0,   1'b0, 1'b1, '{8'h00, 5'd0}},
        '{CMD_KBD,   8'h00, 9'd0,   1'b0, 1'b1, '{8'h00, 5'd0}},
        // latch the widest key, read it, then read it cleared
        '{CMD_KEY,   8'hFF, 9'h1FF, 1'b1, 1'b1, '{8'h00, 5'd0}},
        '{CMD_KBD,   8'h00, 9'd0,   1'b0, 1'b1, '{8'hFF, 5'd0}},
        '{CMD_KBD,   8'h01, 9'd0,   1'b0, 1'b1, '{8'h00, 5'd0}},
        // backspace at column 0 only rewrites the cursor mark
        '{CMD_WRITE, {1'b0, BS_CODE}, 9'd0, 1'b0, 1'b1, '{8'h00, 5'd0}},
        // printable, high bit masked off, top code, ignored control codes
        '{CMD_WRITE, 8'h48, 9'd0,   1'b0, 1'b1, '{8'h00, 5'd1}},
        '{CMD_WRITE, 8'hC8, 9'd0,   1'b0, 1'b1, '{8'h00, 5'd2}},
        '{CMD_WRITE, {1'b0, MARK_CODE}, 9'd0, 1'b0, 1'b1, '{8'h00, 5'd3}},
        '{CMD_WRITE, 8'h00, 9'd0,   1'b0, 1'b1, '{8'h00, 5'd3}},
        '{CMD_WRITE, 8'h01, 9'd0,   1'b0, 1'b1, '{8'h00, 5'd3}},
        // backspace plain and with the high bit set
        '{CMD_WRITE, {1'b0, BS_CODE}, 9'd0, 1'b0, 1'b1, '{8'h00, 5'd2}},
        '{CMD_WRITE, {1'b1, BS_CODE}, 9'd0, 1'b0, 1'b1, '{8'h00, 5'd1}},
        '{CMD_READ,  8'h00, 9'd480, 1'b0, 1'b1, '{8'h48, 5'd1}},
        '{CMD_READ,  8'h00, 9'd481, 1'b0, 1'b1, '{{1'b0, MARK_CODE}, 5'd1}},
        '{CMD_READ,  8'h00, 9'd482, 1'b0, 1'b0, '{8'h00, 5'd0}},
        // carriage return fills and scrolls, then the old row moves up
        '{CMD_WRITE, {1'b0, CR_CODE}, 9'd0, 1'b0, 1'b1, '{8'h00, 5'd0}},
        '{CMD_READ,  8'h00, 9'd448, 1'b0, 1'b0, '{8'h00, 5'd0}},
        '{CMD_WRITE, {1'b1, CR_CODE}, 9'd0, 1'b1, 1'b0, '{8'h00, 5'd0}},
        '{CMD_READ,  8'h00, 9'd416, 1'b1, 1'b0, '{8'h00, 5'd0}}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;   // [7:0] data, [16:8] offset, [17] running
    logic [CMD_W-1:0]     s_axis_tuser;   // [1:0] cmd
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;   // [7:0] read_data, [12:8] cursor_column

    // shadow copy of the block state
    logic [CHAR_W-1:0] shadow_screen [CELLS];
    int                shadow_cursor;
    logic [DATA_W-1:0] shadow_key;

    t_port_result pending_results [$];
    int           mismatch_count = 0;
    int           cycle_count = 0;
    int           send_idle = 0;
    int           recv_stall = 0;

    t_cmd              gen_cmd;
    logic [DATA_W-1:0] gen_data;
    logic [OFF_W-1:0]  gen_offset;
    logic              gen_running;
    int                gen_pick;

    glass_teletype_video_and_key_latch dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // one accepted transaction applied to the shadow state
    function automatic t_port_result step_teletype(t_cmd cmd, logic [DATA_W-1:0] data,
                                                   logic [OFF_W-1:0] offset, logic running);
        t_port_result      res;
        logic [CHAR_W-1:0] ch;
        int                col;
        res = '0;
        case (cmd)
            CMD_WRITE: begin
                ch  = data[CHAR_W-1:0];
                col = shadow_cursor;
                if (ch == BS_CODE && col > 0) begin
                    shadow_screen[BOTTOM_BASE + col] = SPACE_CODE;
                    col--;
                    shadow_screen[BOTTOM_BASE + col] = SPACE_CODE;
                end
                if (ch == CR_CODE) begin
                    while (col < COLUMNS) begin
                        shadow_screen[BOTTOM_BASE + col] = SPACE_CODE;
                        col++;
                    end
                end
                if (ch >= SPACE_CODE) begin
                    shadow_screen[BOTTOM_BASE + col] = ch;
                    col++;
                end
                // scroll up one row and blank the new bottom row
                if (col >= COLUMNS) begin
                    col = 0;
                    for (int p = 0; p < BOTTOM_BASE; p++)
                        shadow_screen[p] = shadow_screen[p + COLUMNS];
                    for (int p = 0; p < COLUMNS; p++)
                        shadow_screen[BOTTOM_BASE + p] = SPACE_CODE;
                end
                shadow_screen[BOTTOM_BASE + col] = MARK_CODE;
                shadow_cursor = col;
            end
            CMD_READ: begin
                if (offset < CELLS)
                    res.read_data = {1'b0, shadow_screen[offset]};
            end
            CMD_KEY: begin
                if (data != '0 && running)
                    shadow_key = data;
            end
            default: begin
                res.read_data = shadow_key;
                shadow_key = '0;
            end
        endcase
        res.cursor = CUR_OUT_W'(shadow_cursor);
        return res;
    endfunction

    // drive one transaction, record its result, then idle at random
    task automatic send_item(t_cmd cmd, logic [DATA_W-1:0] data, logic [OFF_W-1:0] offset,
                             logic running, logic typed, t_port_result typed_res);
        t_port_result predicted;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, running, offset, data};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = step_teletype(cmd, data, offset, running);
        pending_results.push_back(typed ? typed_res : predicted);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // result side: random stalls and comparison with the oldest expectation
    always @(posedge i_clk) begin
        t_port_result want;
        m_axis_tready <= ($urandom_range(99) >= recv_stall);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected result transaction: tdata %h", m_axis_tdata);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[7:0] !== want.read_data
                        || m_axis_tdata[12:8] !== want.cursor) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("result mismatch: read_data exp %h got %h, cursor exp %0d got %0d",
                                 want.read_data, m_axis_tdata[7:0], want.cursor,
                                 m_axis_tdata[12:8]);
                end
            end
        end
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_WRITE;
        for (int p = 0; p < CELLS; p++)
            shadow_screen[p] = SPACE_CODE;
        shadow_screen[BOTTOM_BASE] = MARK_CODE;
        shadow_cursor = 0;
        shadow_key    = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows, no idling
        foreach (DIRECTED_ROWS[i])
            send_item(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].offset,
                      DIRECTED_ROWS[i].running, DIRECTED_ROWS[i].typed,
                      DIRECTED_ROWS[i].result);

        // random phases, each ending with a pause until all results are back
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            send_idle  = PHASE_IDLE[ph];
            recv_stall = PHASE_STALL[ph];
            for (int n = 0; n < RANDOM_ITEMS / PHASE_COUNT; n++) begin
                gen_pick    = $urandom_range(99);
                gen_data    = DATA_W'($urandom_range(255));
                gen_offset  = OFF_W'($urandom_range(CELLS - 1));
                gen_running = ($urandom_range(99) < 80);
                if (gen_pick < 50) begin
                    // mostly text lines with edits, some noise
                    gen_cmd  = CMD_WRITE;
                    gen_pick = $urandom_range(99);
                    if (gen_pick < 70)
                        gen_data = {($urandom_range(99) < 15), 7'($urandom_range(126, 32))};
                    else if (gen_pick < 82)
                        gen_data = {1'($urandom_range(1)), BS_CODE};
                    else if (gen_pick < 90)
                        gen_data = {1'($urandom_range(1)), CR_CODE};
                    else if (gen_pick < 94)
                        gen_data = {1'($urandom_range(1)), MARK_CODE};
                end else if (gen_pick < 75) begin
                    // reads favor the two bottom rows where text changes
                    gen_cmd = CMD_READ;
                    if ($urandom_range(99) < 60)
                        gen_offset = OFF_W'($urandom_range(CELLS - 1, CELLS - 2 * COLUMNS));
                end else if (gen_pick < 87) begin
                    gen_cmd = CMD_KEY;
                    if ($urandom_range(99) < 10)
                        gen_data = '0;
                end else begin
                    gen_cmd = CMD_KBD;
                end
                send_item(gen_cmd, gen_data, gen_offset, gen_running, 1'b0, '0);
            end
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while (pending_results.size() != 0);
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
